@@ src/ehs_pkg.sv @@
// Package for the exception handler stack: sizes, action and status codes,
// the control word layout and the microcode table. No dependencies.
`default_nettype none

package ehs_pkg;

   localparam int HANDLER_DEPTH = 32;
   localparam int ADDR_W = $clog2(HANDLER_DEPTH);
   localparam int CNT_W = $clog2(HANDLER_DEPTH + 1);
   localparam int STEP_W = 4;

   localparam logic [1:0] ACT_PUSH = 2'd0;
   localparam logic [1:0] ACT_POP = 2'd1;
   localparam logic [1:0] ACT_THROW = 2'd2;
   localparam logic [1:0] ACT_IDLE = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_MISS = 2'd3;

   localparam logic [STEP_W-1:0] STEP_FETCH = 4'd0;
   localparam logic [STEP_W-1:0] STEP_PUSH = 4'd1;
   localparam logic [STEP_W-1:0] STEP_EMIT_PUSH = 4'd2;
   localparam logic [STEP_W-1:0] STEP_POP = 4'd3;
   localparam logic [STEP_W-1:0] STEP_EMIT_OK = 4'd4;
   localparam logic [STEP_W-1:0] STEP_THROW = 4'd5;
   localparam logic [STEP_W-1:0] STEP_THROW_CMP = 4'd6;
   localparam logic [STEP_W-1:0] STEP_EMIT_FOUND = 4'd7;
   localparam logic [STEP_W-1:0] STEP_EMIT_MISS = 4'd8;
   localparam logic [STEP_W-1:0] STEP_EMIT_EMPTY = 4'd9;
   localparam logic [STEP_W-1:0] STEP_EMIT_FULL = 4'd10;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_DISPATCH,
      COND_FULL,
      COND_EMPTY,
      COND_NOMATCH
   } cond_type;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_PUSH,
      SEL_FOUND
   } sel_type;

   typedef struct packed {
      logic accept;
      logic push;
      logic pop;
      logic mem_rd;
      logic emit;
      logic [1:0] status;
      sel_type sel;
      cond_type cond;
      logic [STEP_W-1:0] target;
   } ctl_word_type;

   typedef struct packed {
      logic req_valid;
      logic out_free;
      logic full;
      logic empty;
      logic match;
      logic [1:0] action;
   } flags_type;

   typedef struct packed {
      logic [15:0] base;
      logic [31:0] pc;
      logic [7:0] reg_idx;
   } entry_type;

   function automatic logic [STEP_W-1:0] dispatch_target(input logic [1:0] action);
      logic [STEP_W-1:0] t;
      unique case (action)
         ACT_PUSH: t = STEP_PUSH;
         ACT_POP: t = STEP_POP;
         ACT_THROW: t = STEP_THROW;
         ACT_IDLE: t = STEP_EMIT_OK;
         default: t = STEP_EMIT_OK;
      endcase
      return t;
   endfunction

   function automatic ctl_word_type ucode(input logic [STEP_W-1:0] step);
      ctl_word_type w;
      w = '0;
      w.sel = SEL_ZERO;
      w.cond = COND_ALWAYS;
      w.target = STEP_FETCH;
      unique case (step)
         STEP_FETCH: begin
            w.accept = 1'b1;
            w.cond = COND_DISPATCH;
         end
         STEP_PUSH: begin
            w.push = 1'b1;
            w.cond = COND_FULL;
            w.target = STEP_EMIT_FULL;
         end
         STEP_EMIT_PUSH: begin
            w.emit = 1'b1;
            w.sel = SEL_PUSH;
         end
         STEP_POP: begin
            w.pop = 1'b1;
            w.cond = COND_EMPTY;
            w.target = STEP_EMIT_EMPTY;
         end
         STEP_EMIT_OK: begin
            w.emit = 1'b1;
         end
         STEP_THROW: begin
            w.pop = 1'b1;
            w.mem_rd = 1'b1;
            w.cond = COND_EMPTY;
            w.target = STEP_EMIT_MISS;
         end
         STEP_THROW_CMP: begin
            w.cond = COND_NOMATCH;
            w.target = STEP_THROW;
         end
         STEP_EMIT_FOUND: begin
            w.emit = 1'b1;
            w.sel = SEL_FOUND;
         end
         STEP_EMIT_MISS: begin
            w.emit = 1'b1;
            w.status = ST_MISS;
         end
         STEP_EMIT_EMPTY: begin
            w.emit = 1'b1;
            w.status = ST_EMPTY;
         end
         STEP_EMIT_FULL: begin
            w.emit = 1'b1;
            w.status = ST_FULL;
         end
         default: begin
            w.cond = COND_ALWAYS;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ src/ehs_channels.sv @@
// Valid/ready channel interfaces for the request and response words of the
// exception handler stack. No dependencies.
`default_nettype none

interface ehs_req_if;
   logic valid;
   logic ready;
   logic [1:0] action;
   logic [15:0] active_base;
   logic [31:0] handler_pc;
   logic [7:0] handler_reg;

   modport source (output valid, action, active_base, handler_pc, handler_reg,
                   input ready);
   modport sink (input valid, action, active_base, handler_pc, handler_reg,
                 output ready);
endinterface

interface ehs_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [31:0] resume_pc;
   logic [15:0] resume_base;
   logic [16:0] value_slot;

   modport source (output valid, status, resume_pc, resume_base, value_slot,
                   input ready);
   modport sink (input valid, status, resume_pc, resume_base, value_slot,
                 output ready);
endinterface

`default_nettype wire

@@ src/ehs_sequencer.sv @@
// Microcode sequencer: step counter, control word lookup and conditional
// jumps. Depends on ehs_pkg.
`default_nettype none

module ehs_sequencer (
   input wire logic clock,
   input wire logic reset,
   input wire ehs_pkg::flags_type flags,
   output ehs_pkg::ctl_word_type ctl
);

   logic [ehs_pkg::STEP_W-1:0] step_ff;
   logic [ehs_pkg::STEP_W-1:0] step_in;
   logic hold;

   assign ctl = ehs_pkg::ucode(step_ff);
   assign hold = (ctl.accept && !flags.req_valid) || (ctl.emit && !flags.out_free);

   always_comb begin
      step_in = step_ff + 1'b1;
      case (ctl.cond)
         ehs_pkg::COND_ALWAYS: step_in = ctl.target;
         ehs_pkg::COND_DISPATCH: step_in = ehs_pkg::dispatch_target(flags.action);
         ehs_pkg::COND_FULL: if (flags.full) step_in = ctl.target;
         ehs_pkg::COND_EMPTY: if (flags.empty) step_in = ctl.target;
         ehs_pkg::COND_NOMATCH: if (!flags.match) step_in = ctl.target;
         default: step_in = step_ff + 1'b1;
      endcase
      if (hold) begin
         step_in = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ehs_pkg::STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

@@ src/exception_handler_stack_top.sv @@
// Top level of the exception handler stack: handler memory, count, request
// latch and response register, driven by ehs_sequencer. Depends on ehs_pkg
// and the channel interfaces.
// A push or a pop passes through the fetch step that accepts the request,
// one step of work and the step that loads the response register. A request
// with the unused action code goes from the fetch step straight to the step
// that loads the response register. A throw examines one entry at a time,
// each a read of the handler memory's registered port followed by a compare;
// a throw that discards every entry, or meets an empty stack, ends with one
// more read step that finds the stack empty. A finished response waits in the
// output register, and the next request is taken meanwhile. No clearing pass
// is needed after reset.
`default_nettype none

module exception_handler_stack_top (
   input wire logic clock,
   input wire logic reset,
   ehs_req_if.sink req_port,
   ehs_rsp_if.source rsp_port
);

   ehs_pkg::ctl_word_type ctl;
   ehs_pkg::flags_type flags;

   logic [ehs_pkg::CNT_W-1:0] count_ff;
   logic [ehs_pkg::CNT_W-1:0] count_in;
   logic [1:0] action_ff;
   logic [15:0] cur_base_ff;
   logic [31:0] pc_ff;
   logic [7:0] reg_ff;
   ehs_pkg::entry_type rd_ff;
   ehs_pkg::entry_type mem [ehs_pkg::HANDLER_DEPTH];
   logic rsp_valid_ff;
   logic [1:0] status_ff;
   logic [31:0] resume_pc_ff;
   logic [15:0] resume_base_ff;
   logic [16:0] value_slot_ff;

   logic full;
   logic empty;
   logic accept_fire;
   logic emit_fire;
   logic push_fire;
   logic pop_fire;
   logic out_free;
   logic [ehs_pkg::ADDR_W-1:0] rd_addr;

   assign full = (count_ff == ehs_pkg::CNT_W'(ehs_pkg::HANDLER_DEPTH));
   assign empty = (count_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign accept_fire = ctl.accept && req_port.valid;
   assign emit_fire = ctl.emit && out_free;
   assign push_fire = ctl.push && !full;
   assign pop_fire = ctl.pop && !empty;
   assign rd_addr = ehs_pkg::ADDR_W'(count_ff - 1'b1);

   assign flags.req_valid = req_port.valid;
   assign flags.out_free = out_free;
   assign flags.full = full;
   assign flags.empty = empty;
   assign flags.match = (rd_ff.base <= cur_base_ff);
   assign flags.action = accept_fire ? req_port.action : action_ff;

   assign req_port.ready = ctl.accept && !reset;
   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.status = status_ff;
   assign rsp_port.resume_pc = resume_pc_ff;
   assign rsp_port.resume_base = resume_base_ff;
   assign rsp_port.value_slot = value_slot_ff;

   ehs_sequencer u_seq (
      .clock(clock),
      .reset(reset),
      .flags(flags),
      .ctl(ctl)
   );

   always_comb begin
      count_in = count_ff;
      if (push_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_fire) begin
         action_ff <= req_port.action;
         cur_base_ff <= req_port.active_base;
         pc_ff <= req_port.handler_pc;
         reg_ff <= req_port.handler_reg;
      end
      if (emit_fire) begin
         status_ff <= ctl.status;
         case (ctl.sel)
            ehs_pkg::SEL_PUSH: begin
               resume_pc_ff <= pc_ff;
               resume_base_ff <= '0;
               value_slot_ff <= '0;
            end
            ehs_pkg::SEL_FOUND: begin
               resume_pc_ff <= rd_ff.pc;
               resume_base_ff <= rd_ff.base;
               value_slot_ff <= {1'b0, rd_ff.base} + {9'b0, rd_ff.reg_idx};
            end
            default: begin
               resume_pc_ff <= '0;
               resume_base_ff <= '0;
               value_slot_ff <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem[count_ff[ehs_pkg::ADDR_W-1:0]] <= '{base: cur_base_ff, pc: pc_ff,
                                                 reg_idx: reg_ff};
      end
      if (ctl.mem_rd) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= ehs_pkg::CNT_W'(ehs_pkg::HANDLER_DEPTH))
      else $error("Handler count exceeds the stack depth.");

   assert property (@(posedge clock) disable iff (reset)
      emit_fire && ctl.sel == ehs_pkg::SEL_FOUND |-> rd_ff.base <= cur_base_ff)
      else $error("Throw resumed at a handler above the current frame base.");

   assert property (@(posedge clock) disable iff (reset)
      push_fire && !ctl.emit |=> count_ff == $past(count_ff) + 1'b1)
      else $error("Accepted push did not raise the handler count.");

   assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> rsp_valid_ff && status_ff == $past(ctl.status))
      else $error("Response register missed a finished word.");

endmodule

`default_nettype wire
